[design/tcw_pkg.sv]
// Package for the text console character writer: screen geometry, derived
// widths, character and operation codes, and the screen command struct.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry
   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLS * ROWS;

   // Derived widths
   localparam int COL_W  = $clog2(COLS);
   localparam int CNW    = $clog2(COLS + 4);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CELL_W = $clog2(CELL_COUNT);
   localparam int IDX_W  = 11;
   localparam int DATA_W = 16;

   // Blank cell: space with attribute 0x07
   localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [7:0]        ATTR_DEFAULT = 8'h07;

   // Operation codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Character codes
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

   // Command from the cursor control to the screen store
   typedef struct packed {
      logic              clear;
      logic              scroll;
      logic              wr_en;
      logic [CELL_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [CELL_W-1:0] rd_addr;
   } scr_cmd_type;

endpackage

[design/tcw_screen.sv]
// Screen store of the text console: the cell memory and the sequencer that
// sweeps it for clear, scroll copy and bottom-row fill.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_screen import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scr_cmd_type       cmd,
   output logic              busy,
   output logic [DATA_W-1:0] rd_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CLEAR = 2'd1;
   localparam logic [1:0] S_COPY  = 2'd2;
   localparam logic [1:0] S_FILL  = 2'd3;

   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);
   localparam logic [CELL_W-1:0] LAST_BASE = CELL_W'(CELL_COUNT - COLS);

   logic [DATA_W-1:0] mem [CELL_COUNT];

   logic [1:0]        state_ff, state_in;
   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic              cp_vld_ff, cp_vld_in;
   logic [CELL_W-1:0] cp_addr_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic              mem_we;
   logic [CELL_W-1:0] mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic              mem_re;
   logic [CELL_W-1:0] mem_ra;

   // Select the memory port owner
   always_comb begin
      mem_we = 1'b0;
      mem_wa = cnt_ff;
      mem_wd = BLANK_CELL;
      mem_re = 1'b0;
      mem_ra = cmd.rd_addr;
      case (state_ff)
         S_IDLE: begin
            mem_we = cmd.wr_en;
            mem_wa = cmd.wr_addr;
            mem_wd = cmd.wr_data;
            mem_re = cmd.rd_en;
            mem_ra = cmd.rd_addr;
         end
         S_CLEAR, S_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = BLANK_CELL;
         end
         S_COPY: begin
            // read one row ahead, write the cell read last cycle
            mem_we = cp_vld_ff;
            mem_wa = cp_addr_ff;
            mem_wd = rd_data_ff;
            mem_re = (cnt_ff != LAST_BASE);
            mem_ra = cnt_ff + CELL_W'(COLS);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Cell memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // Advance the sweep sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cp_vld_in = cp_vld_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.clear) begin
               state_in = S_CLEAR;
               cnt_in   = '0;
            end else if (cmd.scroll) begin
               state_in  = S_COPY;
               cnt_in    = '0;
               cp_vld_in = 1'b0;
            end
         end
         S_CLEAR: begin
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_COPY: begin
            cp_vld_in = mem_re;
            if (cnt_ff == LAST_BASE) begin
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FILL: begin
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold sequencer state; reset starts a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         cnt_ff    <= '0;
         cp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         cp_vld_ff <= cp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= cnt_ff;
   end

   assign busy    = (state_ff != S_IDLE);
   assign rd_data = rd_data_ff;

endmodule

[design/text_console_character_writer.sv]
// Text console character writer: top level with cursor control, handshakes
// and the attribute register. Depends on tcw_pkg and tcw_screen.
`timescale 1ns / 1ps

// A character write or tab, newline or carriage return that does not scroll,
// an ignored byte, out-of-range read or unused operation completes in the cycle
// it is accepted and its item appears on the result channel the next cycle. An
// in-range cell read goes through the registered memory read and the wait state.
// The screen memory has one write port, so a clear sweeps the memory cell by cell
// and a scroll does a row-offset copy one cell per cycle, then a blank fill of
// the bottom row. When the sweep ends and the result channel is free, the result
// is loaded and the block returns to idle; the next item is held off until then.
// After reset the block runs a clearing pass before it takes its first item;
// attribute writes are taken at any time. Items are taken one at a time, and a
// new one can be accepted in the same cycle the previous result is taken.

module text_console_character_writer import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_char_code,
   input  logic [10:0]       req_read_index,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [IDX_W-1:0]  rsp_cursor_index,
   output logic [DATA_W-1:0] rsp_cell_data,
   output logic              rsp_scrolled,
   // attribute register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_text_attribute
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   logic              state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CELL_W-1:0] base_ff, base_in;
   logic [7:0]        attr_ff;
   logic              pend_read_ff, pend_read_in;
   logic              pend_scroll_ff, pend_scroll_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_scroll_ff, rsp_scroll_in;

   scr_cmd_type       scr_cmd;
   logic              scr_busy;
   logic [DATA_W-1:0] scr_rd_data;

   logic              rsp_free;
   logic              accept;
   logic              printable;
   logic [CNW-1:0]    col_wide;
   logic [CNW-1:0]    nc;
   logic              row_inc;
   logic              do_scroll;
   logic              read_ok;
   logic              is_write;
   logic              is_clear;
   logic              is_read;
   logic              immediate;
   logic              wait_done;

   tcw_screen u_screen (
      .clock   (clock),
      .reset   (reset),
      .cmd     (scr_cmd),
      .busy    (scr_busy),
      .rd_data (scr_rd_data)
   );

   // Handshakes
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || scr_busy || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Decode the item
   assign is_write  = (req_func == FUNC_WRITE);
   assign is_clear  = (req_func == FUNC_CLEAR);
   assign is_read   = (req_func == FUNC_READ);
   assign printable = (req_char_code >= CH_PRINT_LO) && (req_char_code <= CH_PRINT_HI);
   assign read_ok   = (req_read_index < 11'(CELL_COUNT));

   // Next column and row increment, with wrap
   always_comb begin
      col_wide = CNW'(col_ff);
      nc       = col_wide;
      row_inc  = 1'b0;
      if (req_char_code == CH_LF) begin
         nc      = '0;
         row_inc = 1'b1;
      end else if (req_char_code == CH_CR) begin
         nc = '0;
      end else if (req_char_code == CH_TAB) begin
         nc = (col_wide + CNW'(4)) & ~CNW'(3);
      end else if (printable) begin
         nc = col_wide + CNW'(1);
      end
      if (nc >= CNW'(COLS)) begin
         nc      = '0;
         row_inc = 1'b1;
      end
   end

   assign do_scroll = row_inc && (row_ff == ROW_W'(ROWS - 1));
   assign immediate = (is_write && !do_scroll) || (is_read && !read_ok)
                      || (!is_write && !is_clear && !is_read);
   assign wait_done = (state_ff == ST_WAIT) && !scr_busy && rsp_free;

   // Update cursor and sequencer
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      base_in        = base_ff;
      pend_read_in   = pend_read_ff;
      pend_scroll_in = pend_scroll_ff;
      if (accept) begin
         pend_read_in   = 1'b0;
         pend_scroll_in = 1'b0;
         if (is_write) begin
            col_in = COL_W'(nc);
            if (row_inc && !do_scroll) begin
               row_in  = row_ff + 1'b1;
               base_in = base_ff + CELL_W'(COLS);
            end
            pend_scroll_in = do_scroll;
         end else if (is_clear) begin
            col_in  = '0;
            row_in  = '0;
            base_in = '0;
         end else if (is_read) begin
            pend_read_in = read_ok;
         end
         if (!immediate) begin
            state_in = ST_WAIT;
         end
      end else if (wait_done) begin
         state_in = ST_IDLE;
      end
   end

   // Drive the screen store
   always_comb begin
      scr_cmd         = '0;
      scr_cmd.clear   = accept && is_clear;
      scr_cmd.scroll  = accept && is_write && do_scroll;
      scr_cmd.wr_en   = accept && is_write && printable;
      scr_cmd.wr_addr = base_ff + CELL_W'(col_ff);
      scr_cmd.wr_data = {attr_ff, req_char_code};
      scr_cmd.rd_en   = accept && is_read && read_ok;
      scr_cmd.rd_addr = CELL_W'(req_read_index);
   end

   // Load or drop the result item
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scroll_in = rsp_scroll_ff;
      if (accept && immediate) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = IDX_W'(base_in + CELL_W'(col_in));
         rsp_cell_in   = '0;
         rsp_scroll_in = 1'b0;
      end else if (wait_done) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = IDX_W'(base_ff + CELL_W'(col_ff));
         rsp_cell_in   = pend_read_ff ? scr_rd_data : '0;
         rsp_scroll_in = pend_scroll_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         attr_ff      <= ATTR_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_text_attribute;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_read_ff   <= pend_read_in;
      pend_scroll_ff <= pend_scroll_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_cell_ff    <= rsp_cell_in;
      rsp_scroll_ff  <= rsp_scroll_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_index = rsp_index_ff;
   assign rsp_cell_data    = rsp_cell_ff;
   assign rsp_scrolled     = rsp_scroll_ff;

endmodule

[tb/text_console_character_writer_tb.sv]
// Self-checking testbench for the text console character writer: drives
// write, clear, read and unused items and attribute writes, tracks the screen
// and cursor in a scoreboard class and checks every result. Depends on tcw_pkg and the top-level RTL.
`timescale 1ns / 1ps

// Screen and cursor tracker: predicts each result when its item is accepted
// and compares the results in order of arrival.
class console_scoreboard;

   typedef struct packed {
      logic [10:0] cursor;
      logic [15:0] cell_data;
      logic        scrolled;
   } console_result_t;

   logic [15:0]     cells [tcw_pkg::CELL_COUNT];
   int unsigned     col;
   int unsigned     row;
   logic [7:0]      attribute;
   console_result_t expected_q [$];
   int              errors;
   int              results_seen;

   function new();
      errors       = 0;
      results_seen = 0;
      attribute    = tcw_pkg::ATTR_DEFAULT;
      blank_screen();
   endfunction

   // Fill every cell with a blank and home the cursor
   function void blank_screen();
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
         cells[i] = tcw_pkg::BLANK_CELL;
      end
      col = 0;
      row = 0;
   endfunction

   // Move every row up by one and blank the bottom row
   function void scroll_up();
      for (int i = 0; i + tcw_pkg::COLS < tcw_pkg::CELL_COUNT; i++) begin
         cells[i] = cells[i + tcw_pkg::COLS];
      end
      for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLS; i < tcw_pkg::CELL_COUNT; i++) begin
         cells[i] = tcw_pkg::BLANK_CELL;
      end
   endfunction

   function int unsigned cursor_linear();
      return row * tcw_pkg::COLS + col;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Apply one accepted item and queue the result it must produce
   function void note_request(logic [1:0] func, logic [7:0] ch, logic [10:0] ridx);
      int unsigned     pos;
      console_result_t want;
      want = '0;
      case (func)
         tcw_pkg::FUNC_WRITE: begin
            if (ch == tcw_pkg::CH_LF) begin
               col = 0;
               row++;
            end else if (ch == tcw_pkg::CH_CR) begin
               col = 0;
            end else if (ch == tcw_pkg::CH_TAB) begin
               // next multiple of four, no wrap at the byte width
               col = (col + 4) & ~32'd3;
            end else if (ch >= tcw_pkg::CH_PRINT_LO && ch <= tcw_pkg::CH_PRINT_HI) begin
               pos = cursor_linear();
               if (pos < tcw_pkg::CELL_COUNT) cells[pos] = {attribute, ch};
               col++;
            end
            if (col >= tcw_pkg::COLS) begin
               col = 0;
               row++;
            end
            if (row >= tcw_pkg::ROWS) begin
               row = tcw_pkg::ROWS - 1;
               scroll_up();
               want.scrolled = 1'b1;
            end
         end
         tcw_pkg::FUNC_CLEAR: begin
            blank_screen();
         end
         tcw_pkg::FUNC_READ: begin
            if (ridx < tcw_pkg::CELL_COUNT) want.cell_data = cells[ridx];
         end
         default: begin
         end
      endcase
      want.cursor = 11'(cursor_linear());
      expected_q.push_back(want);
   endfunction

   // Print one line per mismatch and count it
   task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("%0t: result %0d %s got 0x%0h, want 0x%0h",
               $time, results_seen, field, got, want);
      errors++;
   endtask

   // Compare one result with the oldest expectation
   task check_response(logic [10:0] cursor, logic [15:0] cell_data, logic scrolled);
      console_result_t want;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected result, cursor", {5'd0, cursor}, 16'd0);
         return;
      end
      want = expected_q.pop_front();
      if (cursor !== want.cursor) report_mismatch("cursor_index", {5'd0, cursor},
                                                  {5'd0, want.cursor});
      if (cell_data !== want.cell_data) report_mismatch("cell_data", cell_data,
                                                        want.cell_data);
      if (scrolled !== want.scrolled) report_mismatch("scrolled", {15'd0, scrolled},
                                                      {15'd0, want.scrolled});
      results_seen++;
   endtask

endclass

module text_console_character_writer_tb;
   import tcw_pkg::*;

   localparam logic [1:0] FUNC_UNUSED    = 2'd3;
   localparam int         QUIET_LIMIT    = 20000;
   localparam int         PHASE_COUNT    = 6;
   localparam int         ITEMS_PER_PHASE = 185;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_func;
   logic [7:0]        req_char_code;
   logic [10:0]       req_read_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [IDX_W-1:0]  rsp_cursor_index;
   logic [DATA_W-1:0] rsp_cell_data;
   logic              rsp_scrolled;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_text_attribute;

   console_scoreboard screen_sb;
   int                send_idle_pct;
   int                rsp_idle_pct;
   int                quiet_cycles;

   text_console_character_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_index   (rsp_cursor_index),
      .rsp_cell_data      (rsp_cell_data),
      .rsp_scrolled       (rsp_scrolled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Predict on accepted items, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            screen_sb.check_response(rsp_cursor_index, rsp_cell_data, rsp_scrolled);
         end
         if (req_valid && !req_stall) begin
            screen_sb.note_request(req_func, req_char_code, req_read_index);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Present one item after an optional gap and hold it until accepted
   task automatic send_item(input logic [1:0] func, input logic [7:0] ch,
                            input logic [10:0] ridx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_char_code  <= ch;
      req_read_index <= ridx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      while (screen_sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the text attribute register while the block is idle
   task automatic write_attribute(input logic [7:0] value);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      do @(posedge clock); while (!csr_ready);
      screen_sb.attribute = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Pick one random item: mostly text and line control, some reads near the cursor
   task automatic random_item(output logic [1:0] func, output logic [7:0] ch,
                              output logic [10:0] ridx);
      int unsigned pick;
      int unsigned here;
      pick = $urandom_range(999);
      ch   = 8'($urandom_range(255));
      ridx = 11'($urandom_range(2047));
      if (pick < 10) begin
         func = FUNC_CLEAR;
      end else if (pick < 20) begin
         func = FUNC_UNUSED;
      end else if (pick < 270) begin
         func = FUNC_READ;
         here = screen_sb.cursor_linear();
         case ($urandom_range(9))
            0:       ridx = 11'($urandom_range(2047));
            1, 2, 3: ridx = 11'((here == 0) ? 0 : here - 1 - $urandom_range(here > 8 ? 8 : here - 1));
            default: ridx = 11'($urandom_range(CELL_COUNT - 1));
         endcase
      end else begin
         func = FUNC_WRITE;
         pick = $urandom_range(99);
         if (pick < 62)      ch = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
         else if (pick < 74) ch = CH_LF;
         else if (pick < 80) ch = CH_CR;
         else if (pick < 90) ch = CH_TAB;
      end
   endtask

   initial begin
      logic [1:0]  func;
      logic [7:0]  ch;
      logic [10:0] ridx;
      logic [7:0]  attr;

      screen_sb          = new();
      send_idle_pct      = 13;
      rsp_idle_pct       = 72;
      quiet_cycles       = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_func           = FUNC_WRITE;
      req_char_code      = 8'd0;
      req_read_index     = 11'd0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_text_attribute = 8'd0;

      // hold reset, then release it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items with the reset attribute
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd0);
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'(CELL_COUNT - 1));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'(CELL_COUNT));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'h7FF);
      send_item(FUNC_WRITE, 8'h41, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, CH_PRINT_LO, 11'h7FF);
      send_item(FUNC_WRITE, CH_PRINT_HI, 11'd0);
      send_item(FUNC_WRITE, 8'h7F, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, 8'h1F, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, 8'h00, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, 8'hFF, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, CH_TAB, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, CH_TAB, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, CH_CR, 11'($urandom_range(2047)));
      send_item(FUNC_WRITE, CH_LF, 11'($urandom_range(2047)));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd0);
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd1);
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd2);
      send_item(FUNC_UNUSED, 8'hFF, 11'h7FF);
      // run the cursor off the bottom row to scroll the screen
      send_item(FUNC_WRITE, 8'h42, 11'($urandom_range(2047)));
      repeat (ROWS + 1) send_item(FUNC_WRITE, CH_LF, 11'($urandom_range(2047)));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd0);
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'(CELL_COUNT - 2 * COLS));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'(CELL_COUNT - COLS));
      send_item(FUNC_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'd0);
      send_item(FUNC_READ,  8'($urandom_range(255)), 11'(COLS));
      drain_results();

      // random phases: new attribute for each, new idle pattern for each pair
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 13; rsp_idle_pct = 72; end
            1: begin send_idle_pct = 72; rsp_idle_pct = 13; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (phase == 0)      attr = 8'h00;
         else if (phase == 1) attr = 8'hFF;
         else                 attr = 8'($urandom_range(255));
         write_attribute(attr);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            random_item(func, ch, ridx);
            send_item(func, ch, ridx);
         end
         drain_results();
      end

      // let any stray result show up, then decide
      repeat (20) @(posedge clock);
      if (screen_sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
design/tcw_pkg.sv
design/tcw_screen.sv
design/text_console_character_writer.sv
tb/text_console_character_writer_tb.sv
